// File: rtl/stgc_pkg.sv
// Package for the start time group counter: shared types and constants.
// No dependencies; used by stgc_dist and start_time_group_counter.
`timescale 1ns / 1ps
`default_nettype none
package stgc_pkg;

   localparam int GAP_W  = 9;    // clamped frame gap, 0..256
   localparam int DIST_W = 17;   // Q1.16 distance
   localparam int FRAC_W = 16;
   localparam logic [DIST_W-1:0] Q_ONE   = 17'h10000;
   localparam logic [GAP_W-1:0]  GAP_CAP = 9'd256;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GRP,
      ST_GRP_WAIT,
      ST_PASS,
      ST_BIT,
      ST_DIST,
      ST_DECIDE,
      ST_TALLY,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      CSR_NEAR,
      CSR_FAR,
      CSR_LIM_OFF,
      CSR_LIM_ON,
      CSR_MIN_OFF,
      CSR_MIN_ON
   } csr_index_type;

   typedef struct packed {
      logic             go;
      logic [GAP_W-1:0] gap;
      logic [7:0]       near;
      logic [7:0]       far;
   } dist_req_type;

   typedef struct packed {
      logic              done;
      logic [DIST_W-1:0] value;
   } dist_res_type;

endpackage
`default_nettype wire

// File: rtl/stgc_dist.sv
// Distance unit: maps a clamped frame gap to a Q1.16 distance with a
// bit-serial divider, one quotient bit a cycle. Depends on stgc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stgc_dist (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire stgc_pkg::dist_req_type req,
   output      stgc_pkg::dist_res_type res
);

   logic                           busy_ff, busy_in;
   logic [stgc_pkg::GAP_W-1:0]     rem_ff, rem_in;
   logic [7:0]                     div_ff, div_in;
   logic [stgc_pkg::FRAC_W-1:0]    quo_ff, quo_in;
   logic [4:0]                     step_ff, step_in;
   logic                           done_ff, done_in;
   logic [stgc_pkg::DIST_W-1:0]    dist_ff, dist_in;
   logic [stgc_pkg::GAP_W-1:0]     rem2;
   logic [stgc_pkg::GAP_W-1:0]     num;
   logic [stgc_pkg::GAP_W-1:0]     span;

   always_comb begin
      busy_in = busy_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      done_in = 1'b0;
      dist_in = dist_ff;
      num     = req.gap - {1'b0, req.near};
      span    = {1'b0, req.far} - {1'b0, req.near};
      rem2    = {rem_ff[stgc_pkg::GAP_W-2:0], 1'b0};
      if (busy_ff) begin
         // one restoring step: shift, try subtract
         if (rem2 >= {1'b0, div_ff}) begin
            rem_in = rem2 - {1'b0, div_ff};
            quo_in = {quo_ff[stgc_pkg::FRAC_W-2:0], 1'b1};
         end else begin
            rem_in = rem2;
            quo_in = {quo_ff[stgc_pkg::FRAC_W-2:0], 1'b0};
         end
         step_in = step_ff - 5'd1;
         if (step_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            dist_in = {1'b0, quo_in};
         end
      end else if (req.go) begin
         if (req.gap < {1'b0, req.near}) begin
            done_in = 1'b1;
            dist_in = '0;
         end else if (req.gap > {1'b0, req.far}) begin
            done_in = 1'b1;
            dist_in = stgc_pkg::Q_ONE;
         end else if (req.far <= req.near) begin
            done_in = 1'b1;
            dist_in = '0;
         end else if (num == span) begin
            done_in = 1'b1;
            dist_in = stgc_pkg::Q_ONE;
         end else begin
            busy_in = 1'b1;
            rem_in  = num;
            div_in  = span[7:0];
            quo_in  = '0;
            step_in = 5'(stgc_pkg::FRAC_W);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      dist_ff <= dist_in;
   end

   assign res.done  = done_ff;
   assign res.value = dist_ff;

endmodule
`default_nettype wire

// File: rtl/start_time_group_counter.sv
// Start time group counter top level: sequencer, member and size memories,
// configuration registers and result register. Depends on stgc_pkg, stgc_dist.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted start frame is scored against every cluster of its direction
// table. For a cluster of n members the median gap is found by a radix select
// over the gap clamped to 9 bits: nine passes that each stream all n members
// out of the member memory at one read a cycle. The median gap then goes
// through the distance unit, which divides one bit a cycle. After the join or
// open decision, one more sweep over the cluster size memory counts the
// clusters that reach the member minimum. The member memory read port and
// the 16-step divide set the time an item takes. The item port stalls while
// an item is in work; a finished result waits in the output register while
// the next item is taken. Configuration writes are accepted at any time but
// belong to idle periods. No clearing pass runs after reset.
module start_time_group_counter #(
   parameter int MAX_GROUPS  = 64,
   parameter int MAX_MEMBERS = 128,
   parameter int FRAME_BITS  = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [23:0] req_start_frame,
   input  wire logic        req_direction,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [6:0]  rsp_passenger_count,
   output      logic        rsp_joined_existing,
   output      logic [5:0]  rsp_group_index,
   output      logic        rsp_dropped,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [16:0] csr_wr_data
);

   localparam int GW    = $clog2(MAX_GROUPS + 1);
   localparam int SW    = $clog2(MAX_MEMBERS + 1);
   localparam int SDEP  = 2 * MAX_GROUPS;
   localparam int SAW   = $clog2(SDEP);
   localparam int MDEP  = 2 * MAX_GROUPS * MAX_MEMBERS;
   localparam int MAW   = $clog2(MDEP);
   localparam int CMPW  = (SW > 8) ? SW : 8;
   localparam int GAPW  = stgc_pkg::GAP_W;
   localparam int DW    = stgc_pkg::DIST_W;
   localparam logic [MAW-1:0] MG_M = MAW'(MAX_GROUPS);
   localparam logic [MAW-1:0] MM_M = MAW'(MAX_MEMBERS);
   localparam logic [SAW-1:0] MG_S = SAW'(MAX_GROUPS);
   localparam logic [GW-1:0]  MG_G = GW'(MAX_GROUPS);
   localparam logic [SW-1:0]  MM_S = SW'(MAX_MEMBERS);

   function automatic logic [MAW-1:0] member_addr(input logic d,
                                                   input logic [GW-1:0] g,
                                                   input logic [SW-1:0] m);
      logic [MAW-1:0] row;
      row = MAW'(d) * MG_M + MAW'(g);
      return row * MM_M + MAW'(m);
   endfunction

   function automatic logic [SAW-1:0] size_addr(input logic d,
                                                 input logic [GW-1:0] g);
      return SAW'(d) * MG_S + SAW'(g);
   endfunction

   // memories
   logic [FRAME_BITS-1:0] member_mem [MDEP];
   logic [SW-1:0]         size_mem [SDEP];
   logic [FRAME_BITS-1:0] member_rdata_ff;
   logic [SW-1:0]         size_rdata_ff;
   logic                  member_re, member_we, size_re, size_we;
   logic [MAW-1:0]        member_raddr, member_waddr;
   logic [SAW-1:0]        size_raddr, size_waddr;
   logic [SW-1:0]         size_wdata;

   // configuration
   logic [7:0]  near_ff, far_ff, min_off_ff, min_on_ff;
   logic [16:0] lim_off_ff, lim_on_ff;

   // sequencer state
   stgc_pkg::state_type   state_ff, state_in;
   logic [FRAME_BITS-1:0] start_ff, start_in;
   logic                  dir_ff, dir_in;
   logic [GW-1:0]         grp_ff, grp_in;
   logic [SW-1:0]         mem_ff, mem_in;
   logic [SW-1:0]         size_ff, size_in;
   logic [SW-1:0]         k_ff, k_in;
   logic [SW-1:0]         cnt_ff, cnt_in;
   logic [GAPW-1:0]       prefix_ff, prefix_in;
   logic [3:0]            bit_ff, bit_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic [GW-1:0]         best_ff, best_in;
   logic [DW-1:0]         best_d_ff, best_d_in;
   logic [SW-1:0]         best_size_ff, best_size_in;
   logic                  have_best_ff, have_best_in;
   logic                  joined_ff, joined_in;
   logic                  dropped_ff, dropped_in;
   logic [GW-1:0]         gidx_ff, gidx_in;
   logic [GW-1:0]         tally_ff, tally_in;
   logic [GW-1:0]         count_ff [2];
   logic [GW-1:0]         count_in [2];

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] rsp_count_ff, rsp_count_in;
   logic       rsp_joined_ff, rsp_joined_in;
   logic [5:0] rsp_gidx_ff, rsp_gidx_in;
   logic       rsp_dropped_ff, rsp_dropped_in;

   stgc_pkg::dist_req_type dist_req;
   stgc_pkg::dist_res_type dist_res;

   // helpers
   logic [FRAME_BITS+23:0] start_wide;
   logic [FRAME_BITS-1:0]  frame_diff;
   logic [GAPW-1:0]        gap_clamped;
   logic [GAPW-1:0]        hi_mask;
   logic [GAPW-1:0]        prefix_set;
   logic                   gap_hit;
   logic                   issue;
   logic [GW-1:0]          count_cur;
   logic [16:0]            limit_cur;
   logic [7:0]             minm_cur;
   logic [GW+6:0]          tally_wide;
   logic [GW+5:0]          gidx_wide;

   assign start_wide = {{FRAME_BITS{1'b0}}, req_start_frame};
   assign count_cur  = count_ff[dir_ff];
   assign limit_cur  = dir_ff ? lim_on_ff : lim_off_ff;
   assign minm_cur   = dir_ff ? min_on_ff : min_off_ff;
   assign tally_wide = {7'b0, tally_ff};
   assign gidx_wide  = {6'b0, gidx_ff};

   // clamp the gap: anything past 255 frames is beyond far_frames anyway
   always_comb begin
      frame_diff  = (start_ff >= member_rdata_ff) ? start_ff - member_rdata_ff
                                                  : member_rdata_ff - start_ff;
      gap_clamped = (frame_diff > FRAME_BITS'(255)) ? stgc_pkg::GAP_CAP
                                                    : {1'b0, frame_diff[7:0]};
      hi_mask     = {GAPW{1'b1}} << ({1'b0, bit_ff} + 5'd1);
      gap_hit     = ((gap_clamped & hi_mask) == (prefix_ff & hi_mask))
                    && !gap_clamped[bit_ff];
      prefix_set  = prefix_ff | (GAPW'(1) << bit_ff);
   end

   stgc_dist u_dist (
      .clock (clock),
      .reset (reset),
      .req   (dist_req),
      .res   (dist_res)
   );

   assign req_stall = (state_ff != stgc_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      dir_in       = dir_ff;
      grp_in       = grp_ff;
      mem_in       = mem_ff;
      size_in      = size_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      prefix_in    = prefix_ff;
      bit_in       = bit_ff;
      rd_pend_in   = 1'b0;
      best_in      = best_ff;
      best_d_in    = best_d_ff;
      best_size_in = best_size_ff;
      have_best_in = have_best_ff;
      joined_in    = joined_ff;
      dropped_in   = dropped_ff;
      gidx_in      = gidx_ff;
      tally_in     = tally_ff;
      count_in     = count_ff;
      issue        = 1'b0;

      member_re    = 1'b0;
      member_raddr = member_addr(dir_ff, grp_ff, mem_ff);
      member_we    = 1'b0;
      member_waddr = member_addr(dir_ff, best_ff, best_size_ff);
      size_re      = 1'b0;
      size_raddr   = size_addr(dir_ff, grp_ff);
      size_we      = 1'b0;
      size_waddr   = size_addr(dir_ff, best_ff);
      size_wdata   = best_size_ff + SW'(1);

      dist_req.go   = 1'b0;
      dist_req.gap  = prefix_ff;
      dist_req.near = near_ff;
      dist_req.far  = far_ff;

      // drop the result once it transfers
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_count_in   = rsp_count_ff;
      rsp_joined_in  = rsp_joined_ff;
      rsp_gidx_in    = rsp_gidx_ff;
      rsp_dropped_in = rsp_dropped_ff;

      case (state_ff)
         stgc_pkg::ST_IDLE: begin
            if (req_valid) begin
               start_in     = start_wide[FRAME_BITS-1:0];
               dir_in       = req_direction;
               grp_in       = '0;
               have_best_in = 1'b0;
               state_in     = stgc_pkg::ST_GRP;
            end
         end
         stgc_pkg::ST_GRP: begin
            if (grp_ff == count_cur) begin
               state_in = stgc_pkg::ST_DECIDE;
            end else begin
               size_re  = 1'b1;
               state_in = stgc_pkg::ST_GRP_WAIT;
            end
         end
         stgc_pkg::ST_GRP_WAIT: begin
            size_in = size_rdata_ff;
            if (size_rdata_ff == '0) begin
               grp_in   = grp_ff + GW'(1);
               state_in = stgc_pkg::ST_GRP;
            end else begin
               k_in      = size_rdata_ff >> 1;
               prefix_in = '0;
               bit_in    = 4'(GAPW - 1);
               mem_in    = '0;
               cnt_in    = '0;
               state_in  = stgc_pkg::ST_PASS;
            end
         end
         stgc_pkg::ST_PASS: begin
            // stream members; count those below the candidate at this bit
            issue      = (mem_ff < size_ff);
            member_re  = issue;
            rd_pend_in = issue;
            if (issue) begin
               mem_in = mem_ff + SW'(1);
            end
            if (rd_pend_ff && gap_hit) begin
               cnt_in = cnt_ff + SW'(1);
            end
            if (!issue && !rd_pend_ff) begin
               state_in = stgc_pkg::ST_BIT;
            end
         end
         stgc_pkg::ST_BIT: begin
            if (k_ff >= cnt_ff) begin
               prefix_in = prefix_set;
               k_in      = k_ff - cnt_ff;
            end
            cnt_in = '0;
            mem_in = '0;
            if (bit_ff == 4'd0) begin
               dist_req.go  = 1'b1;
               dist_req.gap = prefix_in;
               state_in     = stgc_pkg::ST_DIST;
            end else begin
               bit_in   = bit_ff - 4'd1;
               state_in = stgc_pkg::ST_PASS;
            end
         end
         stgc_pkg::ST_DIST: begin
            if (dist_res.done) begin
               // ties go to the later cluster
               if (!have_best_ff || dist_res.value <= best_d_ff) begin
                  best_d_in    = dist_res.value;
                  best_in      = grp_ff;
                  best_size_in = size_ff;
                  have_best_in = 1'b1;
               end
               grp_in   = grp_ff + GW'(1);
               state_in = stgc_pkg::ST_GRP;
            end
         end
         stgc_pkg::ST_DECIDE: begin
            joined_in  = 1'b0;
            dropped_in = 1'b0;
            if (have_best_ff && best_d_ff < limit_cur) begin
               gidx_in = best_ff;
               if (best_size_ff >= MM_S) begin
                  dropped_in = 1'b1;
               end else begin
                  member_we = 1'b1;
                  size_we   = 1'b1;
                  joined_in = 1'b1;
               end
            end else begin
               gidx_in = count_cur;
               if (count_cur >= MG_G) begin
                  dropped_in = 1'b1;
               end else begin
                  member_we        = 1'b1;
                  member_waddr     = member_addr(dir_ff, count_cur, '0);
                  size_we          = 1'b1;
                  size_waddr       = size_addr(dir_ff, count_cur);
                  size_wdata       = SW'(1);
                  count_in[dir_ff] = count_cur + GW'(1);
               end
            end
            grp_in   = '0;
            tally_in = '0;
            state_in = stgc_pkg::ST_TALLY;
         end
         stgc_pkg::ST_TALLY: begin
            issue      = (grp_ff < count_cur);
            size_re    = issue;
            rd_pend_in = issue;
            if (issue) begin
               grp_in = grp_ff + GW'(1);
            end
            if (rd_pend_ff && (CMPW'(size_rdata_ff) >= CMPW'(minm_cur))) begin
               tally_in = tally_ff + GW'(1);
            end
            if (!issue && !rd_pend_ff) begin
               state_in = stgc_pkg::ST_DONE;
            end
         end
         stgc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_count_in   = tally_wide[6:0];
               rsp_joined_in  = joined_ff;
               rsp_gidx_in    = gidx_wide[5:0];
               rsp_dropped_in = dropped_ff;
               state_in       = stgc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stgc_pkg::ST_IDLE;
         end
      endcase
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (member_we) begin
         member_mem[member_waddr] <= start_ff;
      end
      if (member_re) begin
         member_rdata_ff <= member_mem[member_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (size_we) begin
         size_mem[size_waddr] <= size_wdata;
      end
      if (size_re) begin
         size_rdata_ff <= size_mem[size_raddr];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff    <= 8'd3;
         far_ff     <= 8'd24;
         lim_off_ff <= 17'd39322;
         lim_on_ff  <= 17'd65536;
         min_off_ff <= 8'd50;
         min_on_ff  <= 8'd50;
      end else if (csr_wr_en) begin
         case (csr_index)
            stgc_pkg::CSR_NEAR:    near_ff    <= csr_wr_data[7:0];
            stgc_pkg::CSR_FAR:     far_ff     <= csr_wr_data[7:0];
            stgc_pkg::CSR_LIM_OFF: lim_off_ff <= csr_wr_data;
            stgc_pkg::CSR_LIM_ON:  lim_on_ff  <= csr_wr_data;
            stgc_pkg::CSR_MIN_OFF: min_off_ff <= csr_wr_data[7:0];
            stgc_pkg::CSR_MIN_ON:  min_on_ff  <= csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stgc_pkg::ST_IDLE;
         rd_pend_ff   <= 1'b0;
         count_ff[0]  <= '0;
         count_ff[1]  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_ff       <= start_in;
      dir_ff         <= dir_in;
      grp_ff         <= grp_in;
      mem_ff         <= mem_in;
      size_ff        <= size_in;
      k_ff           <= k_in;
      cnt_ff         <= cnt_in;
      prefix_ff      <= prefix_in;
      bit_ff         <= bit_in;
      best_ff        <= best_in;
      best_d_ff      <= best_d_in;
      best_size_ff   <= best_size_in;
      have_best_ff   <= have_best_in;
      joined_ff      <= joined_in;
      dropped_ff     <= dropped_in;
      gidx_ff        <= gidx_in;
      tally_ff       <= tally_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_joined_ff  <= rsp_joined_in;
      rsp_gidx_ff    <= rsp_gidx_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_passenger_count = rsp_count_ff;
   assign rsp_joined_existing = rsp_joined_ff;
   assign rsp_group_index     = rsp_gidx_ff;
   assign rsp_dropped         = rsp_dropped_ff;

   // the cluster tables never grow past their size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff[0] <= MG_G) && (count_ff[1] <= MG_G))
      else $error("cluster count above table size");

   // a start either joins or is dropped, never both
   a_join_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_joined_ff && rsp_dropped_ff))
      else $error("result both joined and dropped");

   // the distance unit answers only while the sequencer waits for it
   a_dist_done: assert property (@(posedge clock) disable iff (reset)
      dist_res.done |-> (state_ff == stgc_pkg::ST_DIST))
      else $error("distance result outside wait state");

   // a new result comes only from the final state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == stgc_pkg::ST_DONE))
      else $error("result loaded outside done state");

endmodule
`default_nettype wire
